### sv/scf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, register codes and constants of the stereo chorus / flanger.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int SMP_W   = 16;          // sample width
    localparam int D_W     = 21;          // delay in samples, Q8
    localparam int DQ_W    = D_W - 8;     // integer part of the delay
    localparam int CNT_W   = 5;

    // delay / 1e6 done as (x >> 6) / 15625 by reciprocal plus one correction
    localparam logic [13:0] US_DIV     = 14'd15625;
    localparam logic [21:0] US_RECIP   = 22'd2199023;   // floor(2**35 / 15625)
    localparam logic [16:0] Q16_ONE    = 17'd65536;
    localparam logic [14:0] CH_LO_US   = 15'd5000;
    localparam logic [14:0] CH_SPAN_US = 15'd25000;
    localparam logic [14:0] FL_LO_US   = 15'd1000;
    localparam logic [14:0] FL_SPAN_US = 15'd4000;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_DRY_WET       = 3'd0,
        REG_FEEDBACK_GAIN = 3'd1,
        REG_MOD_DEPTH     = 3'd2,
        REG_LFO_STEP      = 3'd3,
        REG_PHASE_OFFSET  = 3'd4,
        REG_EFFECT_MODE   = 3'd5,
        REG_SAMPLE_RATE   = 3'd6,
        REG_RING_LENGTH   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [16:0] dry_wet;
        logic [16:0] feedback_gain;
        logic [16:0] mod_depth;
        logic [31:0] lfo_step;
        logic [15:0] phase_offset;
        logic        effect_mode;
        logic [17:0] sample_rate;
        logic [13:0] ring_length;
    } t_cfg;

    // left in the low half
    typedef struct packed {
        logic signed [SMP_W-1:0] right;
        logic signed [SMP_W-1:0] left;
    } t_pair;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // Q15 sine entry k of a table with 2**lg entries; evaluated at elaboration
    function automatic logic signed [SMP_W-1:0] sine_entry(input int unsigned k,
                                                           input int unsigned lg);
        logic [63:0] f;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        f    = 64'(k) << (32 - lg);
        quad = f >> 30;
        r    = f & (ONE_Q30 - 64'd1);
        if ((quad & 64'd1) != 64'd0)
            r = ONE_Q30 - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - ((x2 * ONE_Q30) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (q > 64'd32767)
            q = 64'd32767;
        if (quad >= 64'd2)
            return -$signed({1'b0, q[14:0]});
        return $signed({1'b0, q[14:0]});
    endfunction

endpackage

### sv/scf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_fifo
// Two-word queue between the front end and the processing engine.
// ----------------------------------------------------------------------------
module scf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scf_pkg::t_pair i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output scf_pkg::t_pair o_data
);
    import scf_pkg::*;

    t_pair      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push)
                r_wr <= ~r_wr;
            if (i_pop)
                r_rd <= ~r_rd;
            if (i_push && !i_pop)
                r_count <= r_count + 2'd1;
            else if (!i_push && i_pop)
                r_count <= r_count - 2'd1;
        end
    end

endmodule

### sv/scf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_front
// Register bank on the APB port, input word acceptance and the word queue.
// ----------------------------------------------------------------------------
module scf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,
    input  scf_pkg::t_back_stat i_stat,
    input  logic               i_pop,
    output logic               o_q_valid,
    output scf_pkg::t_pair     o_q_data,
    output scf_pkg::t_cfg      o_cfg
);
    import scf_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     full;
    logic     push;
    logic     wr_en;

    assign pready        = 1'b1;
    assign reg_idx       = t_reg_idx'(paddr[4:2]);
    assign wr_en         = psel && penable && pwrite && pready;
    assign s_axis_tready = !full && !i_stat.clearing;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cfg         = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry_wet       <= 17'd32768;
            r_cfg.feedback_gain <= 17'd32768;
            r_cfg.mod_depth     <= 17'd32768;
            r_cfg.lfo_step      <= 32'd894785;
            r_cfg.phase_offset  <= 16'd0;
            r_cfg.effect_mode   <= 1'b0;
            r_cfg.sample_rate   <= 18'd48000;
            r_cfg.ring_length   <= 14'd8192;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DRY_WET:       r_cfg.dry_wet       <= pwdata[16:0];
                REG_FEEDBACK_GAIN: r_cfg.feedback_gain <= pwdata[16:0];
                REG_MOD_DEPTH:     r_cfg.mod_depth     <= pwdata[16:0];
                REG_LFO_STEP:      r_cfg.lfo_step      <= pwdata;
                REG_PHASE_OFFSET:  r_cfg.phase_offset  <= pwdata[15:0];
                REG_EFFECT_MODE:   r_cfg.effect_mode   <= pwdata[0];
                REG_SAMPLE_RATE:   r_cfg.sample_rate   <= pwdata[17:0];
                REG_RING_LENGTH:   r_cfg.ring_length   <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRY_WET:       prdata = 32'(r_cfg.dry_wet);
            REG_FEEDBACK_GAIN: prdata = 32'(r_cfg.feedback_gain);
            REG_MOD_DEPTH:     prdata = 32'(r_cfg.mod_depth);
            REG_LFO_STEP:      prdata = r_cfg.lfo_step;
            REG_PHASE_OFFSET:  prdata = 32'(r_cfg.phase_offset);
            REG_EFFECT_MODE:   prdata = 32'(r_cfg.effect_mode);
            REG_SAMPLE_RATE:   prdata = 32'(r_cfg.sample_rate);
            REG_RING_LENGTH:   prdata = 32'(r_cfg.ring_length);
            default:           prdata = 32'd0;
        endcase
    end

    scf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (t_pair'(s_axis_tdata)),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_valid (o_q_valid),
        .o_data  (o_q_data)
    );

endmodule

### sv/scf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_back
// Processing engine: LFO, delay calculation, ring buffers, interpolation and
// dry/wet mix for both channels side by side.
// ----------------------------------------------------------------------------
module scf_back #(
    parameter int RING_DEPTH   = 8192,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scf_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  scf_pkg::t_pair      i_q_data,
    output logic                o_pop,
    output scf_pkg::t_back_stat o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scf_pkg::t_pair      o_out_data
);
    import scf_pkg::*;

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int LW     = $clog2(RING_DEPTH + 1);
    localparam int TW     = LW + 8;
    localparam int SIN_LG = $clog2(SINE_ENTRIES);

    typedef logic signed [SMP_W-1:0] t_sine_rom [SINE_ENTRIES];

    function automatic t_sine_rom f_sine_rom();
        t_sine_rom tab;
        for (int k = 0; k < SINE_ENTRIES; k++)
            tab[k] = sine_entry(unsigned'(k), unsigned'(SIN_LG));
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = f_sine_rom();

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_SIN   = 15'b000000000000100,
        S_DEPTH = 15'b000000000001000,
        S_SPAN  = 15'b000000000010000,
        S_RATE  = 15'b000000000100000,
        S_DIV   = 15'b000000001000000,
        S_FIX   = 15'b000000010000000,
        S_MOD   = 15'b000000100000000,
        S_ADDR  = 15'b000001000000000,
        S_WRAP  = 15'b000010000000000,
        S_RDA   = 15'b000100000000000,
        S_RDB   = 15'b001000000000000,
        S_INT   = 15'b010000000000000,
        S_MIX   = 15'b100000000000000
    } t_state;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sh7fff;
        if (v < -40'sd32768)
            return 16'sh8000;
        return v[SMP_W-1:0];
    endfunction

    t_state n_state;
    t_state r_state;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_cur_wp;
    logic [31:0]      r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovalid;
    t_pair            r_odata;

    logic signed [SMP_W-1:0] r_x    [2];
    logic signed [SMP_W-1:0] r_fb   [2];
    logic signed [SMP_W-1:0] r_sin  [2];
    logic [15:0]             r_u    [2];
    logic [30:0]             r_inner[2];
    logic [34:0]             r_num  [2];
    logic [D_W-1:0]          r_dq   [2];
    logic [LW-1:0]           r_mrem [2];
    logic [TW:0]             r_t    [2];
    logic [AW-1:0]           r_x0   [2];
    logic [AW-1:0]           r_x1   [2];
    logic [7:0]              r_fr   [2];
    logic signed [SMP_W-1:0] r_a    [2];
    logic signed [SMP_W-1:0] r_y    [2];

    logic [LW-1:0]           len_eff;
    logic [TW-1:0]           total;
    logic [16:0]             depth_c;
    logic [16:0]             fbg_c;
    logic [16:0]             wet_c;
    logic [14:0]             lo_us;
    logic [14:0]             span_us;
    logic                    out_free;
    logic [31:0]             phase_r;
    logic [SIN_LG-1:0]       sin_idx [2];
    logic                    ring_we;
    logic [AW-1:0]           ring_wa;
    logic signed [SMP_W-1:0] ring_wd [2];
    logic [AW-1:0]           ring_ra [2];
    logic signed [SMP_W-1:0] rd_data [2];

    always_comb begin
        if (i_cfg.ring_length < 14'd2)
            len_eff = LW'(2);
        else if (32'(i_cfg.ring_length) > RING_DEPTH)
            len_eff = LW'(RING_DEPTH);
        else
            len_eff = LW'(i_cfg.ring_length);
    end

    assign total    = {len_eff, 8'h00};
    assign depth_c  = (i_cfg.mod_depth > Q16_ONE) ? Q16_ONE : i_cfg.mod_depth;
    assign fbg_c    = (i_cfg.feedback_gain > Q16_ONE) ? Q16_ONE : i_cfg.feedback_gain;
    assign wet_c    = (i_cfg.dry_wet > Q16_ONE) ? Q16_ONE : i_cfg.dry_wet;
    assign lo_us    = i_cfg.effect_mode ? FL_LO_US : CH_LO_US;
    assign span_us  = i_cfg.effect_mode ? FL_SPAN_US : CH_SPAN_US;
    assign out_free = !r_ovalid || i_out_ready;
    assign phase_r  = r_phase + {i_cfg.phase_offset, 16'h0000};
    assign sin_idx[0] = r_phase[31 -: SIN_LG];
    assign sin_idx[1] = phase_r[31 -: SIN_LG];

    assign o_pop           = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_odata;

    // ring port control
    always_comb begin
        ring_we = 1'b0;
        ring_wa = r_cur_wp;
        for (int c = 0; c < 2; c++) begin
            ring_wd[c] = sat16(40'(r_x[c] + r_fb[c]));
            ring_ra[c] = (r_state == S_RDA) ? r_x0[c] : r_x1[c];
        end
        if (r_state == S_CLEAR) begin
            ring_we = 1'b1;
            ring_wa = r_clr_addr;
            for (int c = 0; c < 2; c++)
                ring_wd[c] = '0;
        end else if (r_state == S_SIN) begin
            ring_we = 1'b1;
        end
    end

    for (genvar c = 0; c < 2; c++) begin : g_ring
        logic signed [SMP_W-1:0] mem [RING_DEPTH];
        logic signed [SMP_W-1:0] r_rd;
        always_ff @(posedge i_clk) begin
            if (ring_we)
                mem[ring_wa] <= ring_wd[c];
            r_rd <= mem[ring_ra[c]];
        end
        assign rd_data[c] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        r_sin[0] <= SINE_ROM[sin_idx[0]];
        r_sin[1] <= SINE_ROM[sin_idx[1]];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(RING_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_q_valid) n_state = S_SIN;
            S_SIN:   n_state = S_DEPTH;
            S_DEPTH: n_state = S_SPAN;
            S_SPAN:  n_state = S_RATE;
            S_RATE:  n_state = S_DIV;
            S_DIV:   n_state = S_FIX;
            S_FIX:   n_state = S_MOD;
            S_MOD:   if (r_cnt == CNT_W'(DQ_W - 1)) n_state = S_ADDR;
            S_ADDR:  n_state = S_WRAP;
            S_WRAP:  n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_INT;
            S_INT:   n_state = S_MIX;
            S_MIX:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_phase    <= 32'd0;
            r_ovalid   <= 1'b0;
            r_cnt      <= '0;
            for (int c = 0; c < 2; c++)
                r_fb[c] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR)
                r_clr_addr <= r_clr_addr + AW'(1);
            if (r_state == S_FIX)
                r_cnt <= '0;
            else if (r_state == S_MOD)
                r_cnt <= r_cnt + CNT_W'(1);
            if (r_state == S_MIX && out_free) begin
                r_ovalid <= 1'b1;
                r_phase  <= r_phase + i_cfg.lfo_step;
                r_wp     <= ((LW'(r_cur_wp) + LW'(1)) >= len_eff) ? '0 : r_cur_wp + AW'(1);
                for (int c = 0; c < 2; c++)
                    r_fb[c] <= sat16(40'((r_y[c] * $signed({1'b0, fbg_c})) >>> 16));
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath, both channels
    always_ff @(posedge i_clk) begin
        logic signed [33:0]   dp;
        logic [48:0]          rate_p;
        logic [56:0]          qp;
        logic [34:0]          qrem;
        logic [LW:0]          mcand;
        logic [TW-1:0]        rp;
        logic [LW-1:0]        x1p;
        logic signed [25:0]   ip;
        logic signed [34:0]   mp;
        logic signed [SMP_W-1:0] o_smp [2];
        for (int c = 0; c < 2; c++) begin
            dp     = r_sin[c] * $signed({1'b0, depth_c});
            rate_p = 49'(i_cfg.sample_rate) * 49'(r_inner[c]);
            qp     = 57'(r_num[c]) * 57'(US_RECIP);
            qrem   = r_num[c] - 35'(r_dq[c]) * 35'(US_DIV);
            mcand  = {r_mrem[c], r_dq[c][D_W-1]};
            rp     = (r_t[c] >= (TW+1)'(total)) ? TW'(r_t[c] - (TW+1)'(total))
                                                : TW'(r_t[c]);
            x1p    = LW'(AW'(rp[TW-1:8])) + LW'(1);
            ip     = (rd_data[c] - r_a[c]) * $signed({1'b0, r_fr[c]});
            mp     = (r_y[c] - r_x[c]) * $signed({1'b0, wet_c});
            o_smp[c] = sat16(40'(r_x[c] + (mp >>> 16)));
            case (r_state)
                S_DEPTH: r_u[c] <= 16'((dp >>> 16) + 34'sd32768);
                S_SPAN:  r_inner[c] <= {lo_us, 16'h0000} + 31'(r_u[c]) * 31'(span_us);
                S_RATE:  r_num[c] <= rate_p[48:14];
                S_DIV:   r_dq[c] <= D_W'(qp >> 35);
                S_FIX: begin
                    // estimate is exact or one low
                    if (qrem >= 35'(US_DIV))
                        r_dq[c] <= r_dq[c] + D_W'(1);
                    r_mrem[c] <= '0;
                end
                S_MOD: begin
                    r_mrem[c] <= (mcand >= (LW+1)'(len_eff)) ? LW'(mcand - (LW+1)'(len_eff))
                                                            : LW'(mcand);
                    r_dq[c]   <= {r_dq[c][D_W-2:0], 1'b0};
                end
                S_ADDR: r_t[c] <= (TW+1)'({r_cur_wp, 8'h00}) + (TW+1)'(total)
                                - (TW+1)'({r_mrem[c], r_dq[c][D_W-1 -: 8]});
                S_WRAP: begin
                    r_x0[c] <= AW'(rp[TW-1:8]);
                    r_fr[c] <= rp[7:0];
                    r_x1[c] <= (x1p >= len_eff) ? '0 : AW'(x1p);
                end
                S_RDB:   r_a[c] <= rd_data[c];
                S_INT:   r_y[c] <= 16'(r_a[c] + (ip >>> 8));
                default: ;
            endcase
        end
        if (o_pop) begin
            r_x[0]   <= i_q_data.left;
            r_x[1]   <= i_q_data.right;
            r_cur_wp <= (LW'(r_wp) >= len_eff) ? '0 : r_wp;
        end
        if (r_state == S_MIX && out_free) begin
            r_odata.left  <= o_smp[0];
            r_odata.right <= o_smp[1];
        end
    end

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clearing pass left to a busy state");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> (r_mrem[0] < len_eff && r_mrem[1] < len_eff))
        else $error("delay remainder not below ring length");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |-> (LW'(r_x0[0]) < len_eff && LW'(r_x0[1]) < len_eff))
        else $error("read tap outside active ring");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX && out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result word not loaded");

endmodule

### sv/stereo_chorus_flanger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_chorus_flanger
// Stereo chorus / flanger: sine LFO modulated delay with feedback and mix.
//
//   channel   signals                       word
//   config    psel penable pwrite paddr ... APB, register i at byte 4*i
//   in        s_axis_t{valid,ready,data}    one stereo pair
//   out       m_axis_t{valid,ready,data}    one processed pair
//
// The engine takes one word at a time and spends most of its work on the bit-serial
// ring-length modulo (13 steps); both channels run side by side.
// After reset a clearing pass zeroes all RING_DEPTH entries of both rings; no
// input word is taken meanwhile, register writes are.
// A two-word queue sits in front of the engine; the result register frees the
// engine while a word waits on m_axis.
// ----------------------------------------------------------------------------
module stereo_chorus_flanger #(
    parameter int RING_DEPTH   = 8192,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_in, [31:16] right_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] left_out, [31:16] right_out
);
    import scf_pkg::*;

    t_cfg       cfg;
    t_back_stat stat;
    t_pair      q_data;
    t_pair      out_data;
    logic       q_valid;
    logic       pop;

    scf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_stat        (stat),
        .i_pop         (pop),
        .o_q_valid     (q_valid),
        .o_q_data      (q_data),
        .o_cfg         (cfg)
    );

    scf_back #(
        .RING_DEPTH   (RING_DEPTH),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule

### tb/stereo_chorus_flanger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_chorus_flanger_tb
// Self-checking bench for the stereo chorus / flanger. A directed table of
// stereo words runs first, then register settings (extremes first, then
// random), each followed by a run of random words. A local model of the
// modulated delay predicts each output word not given by the table.
// Input words come in bursts; the output stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module stereo_chorus_flanger_tb;
    import scf_pkg::*;

    localparam int RING_MAX   = 8192;
    localparam int SINE_N     = 1024;
    localparam int LIMIT      = 3000000;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 106;
    localparam int DRAIN_CYC  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] left_in, [31:16] right_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] left_out, [31:16] right_out

    stereo_chorus_flanger dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // local model state
    int          sine_tab[SINE_N];
    int          ring_mem[2][RING_MAX];
    int          fb_val[2];
    int unsigned wr_pos;
    int unsigned lfo_ph;
    int unsigned c_dry, c_fbg, c_depth, c_step, c_offs, c_mode, c_rate, c_len;

    t_pair       out_q[$];
    int          errors;
    int          cycles;
    int          burst_left;

    typedef struct {
        logic signed [15:0] l;
        logic signed [15:0] r;
        bit                 known;
        logic signed [15:0] el;
        logic signed [15:0] er;
    } t_row;

    t_row rows[20] = '{
        '{16'sd32767,  -16'sd32768, 1, 16'sd16383,  -16'sd16384},
        '{-16'sd32768, 16'sd32767,  1, -16'sd16384, 16'sd16383},
        '{16'sd0,      16'sd0,      1, 16'sd0,      16'sd0},
        '{-16'sd1,     16'sd1,      1, -16'sd1,     16'sd0},
        '{16'sd32767,  16'sd32767,  1, 16'sd16383,  16'sd16383},
        '{-16'sd32768, -16'sd32768, 0, 16'sd0, 16'sd0},
        '{16'sd1,      -16'sd1,     0, 16'sd0, 16'sd0},
        '{16'sd12345,  -16'sd12345, 0, 16'sd0, 16'sd0},
        '{16'sh5555,   16'shaaaa,   0, 16'sd0, 16'sd0},
        '{16'shaaaa,   16'sh5555,   0, 16'sd0, 16'sd0},
        '{16'sd32767,  16'sd0,      0, 16'sd0, 16'sd0},
        '{16'sd0,      -16'sd32768, 0, 16'sd0, 16'sd0},
        '{16'sd100,    16'sd200,    0, 16'sd0, 16'sd0},
        '{-16'sd300,   16'sd400,    0, 16'sd0, 16'sd0},
        '{16'sh7ff0,   16'sh8010,   0, 16'sd0, 16'sd0},
        '{16'sh00ff,   16'shff00,   0, 16'sd0, 16'sd0},
        '{16'sh0f0f,   16'shf0f0,   0, 16'sd0, 16'sd0},
        '{-16'sd2,     16'sd2,      0, 16'sd0, 16'sd0},
        '{16'sd32767,  -16'sd32768, 0, 16'sd0, 16'sd0},
        '{-16'sd32768, 16'sd32767,  0, 16'sd0, 16'sd0}
    };

    function automatic int q15_sine(int unsigned k);
        longint unsigned f, quad, r, x, x2, t, s, q;
        f    = (longint'(k) << 22) & 64'hFFFF_FFFF;
        quad = f >> 30;
        r    = f & (ONE_Q30 - 1);
        if (quad[0])
            r = ONE_Q30 - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - ((x2 * ONE_Q30) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s * 32767 + (ONE_Q30 >> 1)) >> 30;
        if (q > 32767)
            q = 32767;
        return (quad >= 2) ? -int'(q) : int'(q);
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    function automatic longint q16_clamp(int unsigned v);
        return (v > 65536) ? 65536 : longint'(v);
    endfunction

    function automatic longint unsigned delay_samples_q8(int lfo);
        longint          scaled;
        longint unsigned u, lo, span;
        scaled = (longint'(lfo) * q16_clamp(c_depth)) >>> 16;
        u      = longint'(scaled + 32768);
        lo     = c_mode ? 1000 : 5000;
        span   = c_mode ? 4000 : 25000;
        return (longint'(c_rate) * (lo * 65536 + u * span) * 256) / 64'd65536000000;
    endfunction

    function automatic int delay_line(int ch, int x, int unsigned ph, int unsigned len);
        longint unsigned total, d, rp;
        int unsigned     x0, x1, fr;
        longint          y, w;
        total = longint'(len) * 256;
        ring_mem[ch][wr_pos] = sat16(longint'(x) + fb_val[ch]);
        d  = delay_samples_q8(sine_tab[ph >> 22]) % total;
        rp = (longint'(wr_pos) * 256 + total - d) % total;
        x0 = rp >> 8;
        fr = rp & 255;
        x1 = x0 + 1;
        if (x1 >= len)
            x1 = 0;
        y = (longint'(ring_mem[ch][x0]) * longint'(256 - fr) +
             longint'(ring_mem[ch][x1]) * longint'(fr)) >>> 8;
        fb_val[ch] = sat16((y * q16_clamp(c_fbg)) >>> 16);
        w = q16_clamp(c_dry);
        return sat16((longint'(x) * (65536 - w) + y * w) >>> 16);
    endfunction

    function automatic t_pair predict_mix(logic signed [15:0] l, logic signed [15:0] r);
        int unsigned len;
        t_pair       p;
        len = (c_len < 2) ? 2 : (c_len > RING_MAX) ? RING_MAX : c_len;
        if (wr_pos >= len)
            wr_pos = 0;
        p.left  = 16'(delay_line(0, l, lfo_ph, len));
        p.right = 16'(delay_line(1, r, lfo_ph + (c_offs << 16), len));
        lfo_ph += c_step;
        wr_pos++;
        if (wr_pos >= len)
            wr_pos = 0;
        return p;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DRY_WET:       c_dry   = val & 32'h1FFFF;
            REG_FEEDBACK_GAIN: c_fbg   = val & 32'h1FFFF;
            REG_MOD_DEPTH:     c_depth = val & 32'h1FFFF;
            REG_LFO_STEP:      c_step  = val;
            REG_PHASE_OFFSET:  c_offs  = val & 32'hFFFF;
            REG_EFFECT_MODE:   c_mode  = val & 32'h1;
            REG_SAMPLE_RATE:   c_rate  = val & 32'h3FFFF;
            default:           c_len   = val & 32'h3FFF;
        endcase
    endtask

    task automatic write_all(logic [31:0] dw, logic [31:0] fg, logic [31:0] dp,
                             logic [31:0] st, logic [31:0] po, logic [31:0] md,
                             logic [31:0] sr, logic [31:0] rl);
        reg_write(REG_DRY_WET, dw);
        reg_write(REG_FEEDBACK_GAIN, fg);
        reg_write(REG_MOD_DEPTH, dp);
        reg_write(REG_LFO_STEP, st);
        reg_write(REG_PHASE_OFFSET, po);
        reg_write(REG_EFFECT_MODE, md);
        reg_write(REG_SAMPLE_RATE, sr);
        reg_write(REG_RING_LENGTH, rl);
    endtask

    task automatic wait_idle();
        while (out_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // holds tvalid high across back-to-back words; lowered only for a gap
    task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r,
                             bit known, logic signed [15:0] el, logic signed [15:0] er);
        t_pair p;
        int    gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_mix(l, r);
        if (known) begin
            p.left  = el;
            p.right = er;
        end
        out_q.push_back(p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pair got;
        t_pair want;
        cycles <= cycles + 1;
        case ((cycles >> 9) % 3)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
            default: m_axis_tready <= ((cycles % 11) > 3);
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (out_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected word %h", got);
            end else begin
                want = out_q.pop_front();
                if (got !== want) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp L %0d R %0d, got L %0d R %0d",
                                 want.left, want.right, got.left, got.right);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        logic [31:0] rl;
        burst_left    = 0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        for (int k = 0; k < SINE_N; k++)
            sine_tab[k] = q15_sine(k);
        for (int k = 0; k < RING_MAX; k++) begin
            ring_mem[0][k] = 0;
            ring_mem[1][k] = 0;
        end
        fb_val  = '{0, 0};
        wr_pos  = 0;
        lfo_ph  = 0;
        c_dry   = 32768;
        c_fbg   = 32768;
        c_depth = 32768;
        c_step  = 894785;
        c_offs  = 0;
        c_mode  = 0;
        c_rate  = 48000;
        c_len   = 8192;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_pair(rows[i].l, rows[i].r, rows[i].known, rows[i].el, rows[i].er);

        for (p = 0; p < N_PHASES; p++) begin
            s_axis_tvalid <= 1'b0;
            wait_idle();
            case (p)
                0: write_all(65536, 65536, 65536, 32'hFFFF_FFFF, 65535, 1, 192000, 8192);
                1: write_all(0, 0, 0, 0, 0, 0, 8000, 2);
                2: write_all(131071, 131071, 131071, 32'h8000_0001, 32768, 0,
                             262143, 16383);
                3: write_all(40000, 60000, 65536, 32'h0100_0000, 100, 0, 0, 0);
                4: write_all(65536, 20000, 65536, 32'h0010_0000, 16384, 1, 48000, 1);
                5: write_all(50000, 65000, 65536, 32'h0002_0000, 1000, 0, 192000, 300);
                default: begin
                    rl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(2, 8192);
                    write_all($urandom_range(0, 131071), $urandom_range(0, 131071),
                              $urandom_range(0, 131071), $urandom,
                              $urandom_range(0, 65535), $urandom_range(0, 1),
                              ($urandom_range(0, 5) == 0) ? $urandom_range(0, 262143)
                                                          : $urandom_range(8000, 192000),
                              rl);
                end
            endcase
            for (n = 0; n < PHASE_LEN; n++)
                send_pair(rand_sample(), rand_sample(), 0, 16'sd0, 16'sd0);
        end
        s_axis_tvalid <= 1'b0;
        wait_idle();
        if (errors == 0 && out_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### stereo_chorus_flanger.f
sv/scf_pkg.sv
sv/scf_fifo.sv
sv/scf_front.sv
sv/scf_back.sv
sv/stereo_chorus_flanger.sv
tb/stereo_chorus_flanger_tb.sv
